// ===== hw/rtl/e80d_pkg.sv =====
// shared types and constants for the extended80 to double converter
// no dependencies
package e80d_pkg;

    localparam logic [63:0] SIGN_BIT64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_INF64  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] QNAN64     = 64'h7FF8_0000_0000_0000;
    localparam logic [14:0] EXP_ALL1   = 15'h7FFF;

    // special-case kind decided in the first stage
    localparam logic [1:0] KIND_NUM  = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_INF  = 2'd2;
    localparam logic [1:0] KIND_NAN  = 2'd3;

    // stage 1 to stage 2 record
    typedef struct packed {
        logic        sign;
        logic [1:0]  kind;
        logic [14:0] exp;
        logic [63:0] man;
        logic [6:0]  lz;
    } e80d_s1_t;

    // stage 2 to stage 3 record
    typedef struct packed {
        logic        sign;
        logic [1:0]  kind;
        logic [63:0] m;
        logic signed [16:0] be;
    } e80d_s2_t;

    // stage 3 to stage 4 record
    typedef struct packed {
        logic        sign;
        logic [1:0]  kind;
        logic        norm;
        logic signed [16:0] be;
        logic [52:0] q;
        logic        inc;
    } e80d_s3_t;

endpackage

// ===== hw/rtl/e80d_round.sv =====
// rounding stage: shift amount and round-half-even increment
// depends on e80d_pkg
module e80d_round (
    input  e80d_pkg::e80d_s2_t din,
    output e80d_pkg::e80d_s3_t dout
);
    localparam logic [63:0] SIGNHALF = 64'h8000_0000_0000_0000;

    logic [6:0]   d;
    logic [127:0] ext;
    logic [63:0]  q;
    logic [63:0]  rem;
    logic [63:0]  half;
    logic         sub;
    logic signed [16:0] dd;

    // pick shift: 11 for normals, 12-be for subnormals (capped at 65)
    always_comb
    begin
        sub  = (din.be < 17'sd1);
        dd   = 17'sd12 - din.be;
        if (!sub)
            d = 7'd11;
        else if (dd > 17'sd64)
            d = 7'd65;
        else
            d = dd[6:0];
        ext  = {din.m, 64'd0} >> d;
        q    = ext[127:64];
        rem  = ext[63:0];
        half = SIGNHALF;
        dout.sign = din.sign;
        dout.kind = din.kind;
        dout.norm = !sub;
        dout.be   = din.be;
        dout.q    = q[52:0];
        dout.inc  = (rem > half) || (rem == half && q[0]);
    end
endmodule

// ===== hw/rtl/extended80_to_double_convert_top.sv =====
// one request per cycle, while the output stage is empty or being taken
// four register stages: leading-zero count, normalize shift, round, pack
// pipeline advances whenever the output stage is empty or being taken
// reset (rst_n low, asynchronous) clears all valid bits
// depends on e80d_pkg and e80d_round
module extended80_to_double_convert_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // [15:0] sign_and_exponent, [79:16] ext_mantissa
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // [63:0] double_bits
);
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    e80d_pkg::e80d_s1_t s1_reg, s1_next;
    e80d_pkg::e80d_s2_t s2_reg, s2_next;
    e80d_pkg::e80d_s3_t s3_reg, s3_next;
    logic [63:0] out_reg, out_next;

    assign adv      = !v4_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;

    // stage 1: classify and count leading zeros
    always_comb
    begin
        logic [63:0] man;
        man = s_tdata[79:16];
        s1_next.sign = s_tdata[15];
        s1_next.exp  = s_tdata[14:0];
        s1_next.man  = man;
        s1_next.lz   = 7'd64;
        for (int i = 0; i < 64; i++)
            if (man[i])
                s1_next.lz = 7'(63 - i);
        if (s_tdata[14:0] == e80d_pkg::EXP_ALL1)
            s1_next.kind = (man[62:0] == 63'd0) ? e80d_pkg::KIND_INF : e80d_pkg::KIND_NAN;
        else if (man == 64'd0)
            s1_next.kind = e80d_pkg::KIND_ZERO;
        else
            s1_next.kind = e80d_pkg::KIND_NUM;
    end

    // stage 2: normalize and form biased exponent
    always_comb
    begin
        s2_next.sign = s1_reg.sign;
        s2_next.kind = s1_reg.kind;
        s2_next.m    = s1_reg.man << s1_reg.lz[5:0];
        s2_next.be   = $signed({2'b00, s1_reg.exp}) - 17'sd15360
                       - $signed({10'd0, s1_reg.lz});
    end

    // stage 3: rounding
    e80d_round u_round (
        .din  (s2_reg),
        .dout (s3_next)
    );

    // stage 4: pack
    always_comb
    begin
        logic [63:0] q;
        logic [63:0] sgn;
        sgn = {s3_reg.sign, 63'd0};
        q   = {11'd0, s3_reg.q} + {63'd0, s3_reg.inc};
        case (s3_reg.kind)
            e80d_pkg::KIND_INF:  out_next = sgn | e80d_pkg::EXP_INF64;
            e80d_pkg::KIND_NAN:  out_next = sgn | e80d_pkg::QNAN64;
            e80d_pkg::KIND_ZERO: out_next = sgn;
            default:
            begin
                if (s3_reg.be >= 17'sd2047)
                    out_next = sgn | e80d_pkg::EXP_INF64;
                else if (s3_reg.norm)
                begin
                    q = {1'b0, 11'(s3_reg.be - 17'sd1), 52'd0} + q;
                    out_next = (q >= e80d_pkg::EXP_INF64) ? (sgn | e80d_pkg::EXP_INF64)
                                                          : (sgn | q);
                end
                else
                    out_next = sgn | q;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            out_reg <= out_next;
        end
    end
endmodule

// ===== hw/rtl/e80d_checker.sv =====
// port-level checker for the converter, bound to the top level
// depends on extended80_to_double_convert_top
module e80d_port_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // input side open whenever output free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("ready low with empty output");

    // a stalled output blocks new requests
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("ready high while stalled");
endmodule

bind extended80_to_double_convert_top e80d_port_props u_chk (.*);

// ===== test/e80d_checker.sv =====
// result checker for the extended80 to double converter: watches both stream channels,
// predicts each double from the accepted request and compares it with the result stream
// depends on nothing but its ports
module e80d_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    logic [63:0] double_queue[$];

    // round normalized m right by d bits, ties to even
    function automatic logic [63:0] shift_round_even(logic [63:0] m, int d);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (d >= 64)
        begin
            q = 64'd0;
            rem = m;
            half = 64'h8000_0000_0000_0000;
        end
        else
        begin
            q = m >> d;
            half = 64'd1 << (d - 1);
            rem = m & ((half << 1) - 64'd1);
        end
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    // extended80 value to binary64 bits
    function automatic logic [63:0] to_double(logic [15:0] se, logic [63:0] man);
        logic [63:0] sgn;
        logic [63:0] m;
        logic [63:0] q;
        int          e;
        int          lz;
        int          be;
        sgn = {se[15], 63'd0};
        e = int'(se[14:0]);
        if (e == 32767)
            return (man[62:0] == 63'd0) ? (sgn | 64'h7FF0_0000_0000_0000)
                                        : (sgn | 64'h7FF8_0000_0000_0000);
        if (man == 64'd0)
            return sgn;
        lz = 0;
        while (!man[63 - lz])
            lz++;
        m = man << lz;
        be = e - 16383 - lz + 1023;
        if (be >= 2047)
            return sgn | 64'h7FF0_0000_0000_0000;
        if (be >= 1)
        begin
            // significand carry may ripple into the exponent
            q = (64'(be - 1) << 52) + shift_round_even(m, 11);
            if (q >= 64'h7FF0_0000_0000_0000)
                return sgn | 64'h7FF0_0000_0000_0000;
            return sgn | q;
        end
        if (12 - be > 64)
            return sgn;
        return sgn | shift_round_even(m, 12 - be);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            pending = 0;
            double_queue.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (double_queue.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    logic [63:0] want;
                    want = double_queue.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("double_bits got %h want %h",
                                                  m_tdata, want));
                end
            end
            if (s_tvalid && s_tready)
                double_queue.push_back(to_double(s_tdata[15:0], s_tdata[79:16]));
            pending = double_queue.size();
        end
    end

endmodule

// ===== test/extended80_to_double_convert_top_tb.sv =====
// stimulus and verdict for the extended80 to double converter
// depends on extended80_to_double_convert_top and e80d_checker
module extended80_to_double_convert_top_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // [15:0] sign_and_exponent, [79:16] ext_mantissa
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] double_bits
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          calm;

    extended80_to_double_convert_top uut (.*);

    e80d_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 200000)
        begin
            $display("extended80_to_double_convert_top regression: fail");
            $finish;
        end
    end

    // random result stall, none during the calm stretch
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= 12);

    // one request, held until accepted, with random idle cycles ahead of it
    task automatic send_request(logic [15:0] se, logic [63:0] man);
        while (!calm && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {man, se};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random exponent, biased toward the double range edges
    function automatic logic [15:0] pick_exponent();
        logic [14:0] e;
        case ($urandom_range(5))
            0: e = 15'($urandom);
            1: e = 15'(16383 - 1023 + $urandom_range(40) - 20);
            2: e = 15'(16383 + 1024 + $urandom_range(40) - 20);
            3: e = 15'(16383 - 1074 + $urandom_range(140) - 100);
            4: e = 15'h7FFF;
            default: e = 15'(16383 + $urandom_range(200) - 100);
        endcase
        return {1'($urandom), e};
    endfunction

    function automatic logic [63:0] pick_mantissa();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(5))
            0: m = m >> $urandom_range(63);
            1: m[10:0] = $urandom_range(1) ? 11'h400 : 11'h3FF;
            2: m = 64'hFFFF_FFFF_FFFF_F800 | (m & 64'h7FF);
            3: m = ~64'd0;
            default: m[63] = 1'b1;
        endcase
        return m;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: specials, extremes, rounding edges
        send_request(16'h7FFF, 64'h8000_0000_0000_0000);
        send_request(16'hFFFF, 64'h0000_0000_0000_0000);
        send_request(16'h7FFF, 64'hC000_0000_0000_0000);
        send_request(16'hFFFF, 64'h0000_0000_0000_0001);
        send_request(16'h0000, 64'h0);
        send_request(16'h8000, 64'h0);
        send_request(16'h7FFE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(16'h0000, 64'h0000_0000_0000_0001);
        send_request(16'h400E, 64'hAC44_0000_0000_0000);
        send_request(16'h3FFF, 64'h0000_0000_0000_0001);
        send_request(16'h43FE, 64'hFFFF_FFFF_FFFF_FC00);
        send_request(16'h43FE, 64'hFFFF_FFFF_FFFF_FBFF);
        send_request(16'h3C01, 64'h8000_0000_0000_0000);
        send_request(16'h3C00, 64'hFFFF_FFFF_FFFF_F800);
        send_request(16'h3BCD, 64'h8000_0000_0000_0000);
        send_request(16'hBBCC, 64'h8000_0000_0000_0000);
        send_request(16'h3BCC, 64'h8000_0000_0000_0001);
        send_request(16'h3FFF, 64'h8000_0000_0000_0C00);
        send_request(16'h3FFF, 64'h8000_0000_0000_0400);
        send_request(16'h3FFF, 64'h8000_0000_0000_0401);

        // random part, with a calm stretch in the middle
        for (int i = 0; i < 1550; i++)
        begin
            calm = (i >= 600 && i < 800);
            send_request(pick_exponent(), pick_mantissa());
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("extended80_to_double_convert_top regression: pass");
        else
            $display("extended80_to_double_convert_top regression: fail");
        $finish;
    end

endmodule

// ===== extended80_to_double_convert_top.f =====
hw/rtl/e80d_pkg.sv
hw/rtl/e80d_round.sv
hw/rtl/extended80_to_double_convert_top.sv
hw/rtl/e80d_checker.sv
test/e80d_checker.sv
test/extended80_to_double_convert_top_tb.sv
